[design/obm_pkg.sv]
// ----------------------------------------------------------------------------
// obm_pkg - shared definitions for the 1-Wire bus master
// Operation codes, phase codes, register indexes, reset values and the
// word, result and configuration types used across the block.
// ----------------------------------------------------------------------------
package obm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    // operation codes of an input word
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // bus phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_LOW = 4'd1;
    localparam logic [3:0] PH_RST_WT  = 4'd2;
    localparam logic [3:0] PH_RST_REC = 4'd3;
    localparam logic [3:0] PH_WR_LOW  = 4'd4;
    localparam logic [3:0] PH_WR_REC  = 4'd5;
    localparam logic [3:0] PH_RD_LOW  = 4'd6;
    localparam logic [3:0] PH_RD_REC  = 4'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TPM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_SMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_REC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WR1_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WR0_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_REC = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW   = 3'd7;

    // register reset values
    localparam logic [6:0] TPM_RESET      = 7'd1;
    localparam logic [8:0] RST_LOW_RESET  = 9'd480;
    localparam logic [8:0] PRES_SMP_RESET = 9'd80;
    localparam logic [8:0] RST_REC_RESET  = 9'd400;
    localparam logic [8:0] WR1_LOW_RESET  = 9'd1;
    localparam logic [8:0] WR0_LOW_RESET  = 9'd60;
    localparam logic [8:0] SLOT_REC_RESET = 9'd60;
    localparam logic [8:0] RD_LOW_RESET   = 9'd2;

    typedef struct packed {
        logic [6:0] ticks_per_microsecond;
        logic [8:0] reset_low_time;
        logic [8:0] presence_sample_time;
        logic [8:0] reset_recovery_time;
        logic [8:0] write_one_low_time;
        logic [8:0] write_zero_low_time;
        logic [8:0] slot_recovery_time;
        logic [8:0] read_low_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] write_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       line_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       command_rejected;
    } t_res;

endpackage

[design/obm_if.sv]
// ----------------------------------------------------------------------------
// obm_if - valid/ready channels of the 1-Wire bus master
// One channel carries input words, the other carries result words.
// ----------------------------------------------------------------------------
interface obm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] write_byte;
    logic       line_level;

    modport source (output valid, output operation, output write_byte,
                    output line_level, input ready);
    modport sink   (input valid, input operation, input write_byte,
                    input line_level, output ready);
endinterface

interface obm_out_if;
    logic       valid;
    logic       ready;
    logic       line_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       command_rejected;

    modport source (output valid, output line_drive_low, output busy_res,
                    output done_res, output presence, output read_byte,
                    output command_rejected, input ready);
    modport sink   (input valid, input line_drive_low, input busy_res,
                    input done_res, input presence, input read_byte,
                    input command_rejected, output ready);
endinterface

[design/obm_cfg.sv]
// ----------------------------------------------------------------------------
// obm_cfg - configuration registers
// Holds the prescale and slot timing registers, written by index.
// ----------------------------------------------------------------------------
module obm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [obm_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [obm_pkg::CFG_DATA_W-1:0]    i_data,
    output obm_pkg::t_cfg                     o_cfg
);

    obm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_microsecond <= obm_pkg::TPM_RESET;
            r_cfg.reset_low_time        <= obm_pkg::RST_LOW_RESET;
            r_cfg.presence_sample_time  <= obm_pkg::PRES_SMP_RESET;
            r_cfg.reset_recovery_time   <= obm_pkg::RST_REC_RESET;
            r_cfg.write_one_low_time    <= obm_pkg::WR1_LOW_RESET;
            r_cfg.write_zero_low_time   <= obm_pkg::WR0_LOW_RESET;
            r_cfg.slot_recovery_time    <= obm_pkg::SLOT_REC_RESET;
            r_cfg.read_low_time         <= obm_pkg::RD_LOW_RESET;
        end else if (i_we) begin
            unique case (i_idx)
                obm_pkg::CFG_TPM:      r_cfg.ticks_per_microsecond <= i_data[6:0];
                obm_pkg::CFG_RST_LOW:  r_cfg.reset_low_time        <= i_data;
                obm_pkg::CFG_PRES_SMP: r_cfg.presence_sample_time  <= i_data;
                obm_pkg::CFG_RST_REC:  r_cfg.reset_recovery_time   <= i_data;
                obm_pkg::CFG_WR1_LOW:  r_cfg.write_one_low_time    <= i_data;
                obm_pkg::CFG_WR0_LOW:  r_cfg.write_zero_low_time   <= i_data;
                obm_pkg::CFG_SLOT_REC: r_cfg.slot_recovery_time    <= i_data;
                obm_pkg::CFG_RD_LOW:   r_cfg.read_low_time         <= i_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/obm_core.sv]
// ----------------------------------------------------------------------------
// obm_core - bus state and per-word update
// Advances the microsecond timers, ends phases, chains through phases of
// zero length in closed form and forms the result word.
// ----------------------------------------------------------------------------
module obm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  obm_pkg::t_item i_item,
    input  obm_pkg::t_cfg  i_cfg,
    output obm_pkg::t_res  o_res
);

    logic [3:0] r_phase, n_phase;
    logic [6:0] r_presc, n_presc;
    logic [8:0] r_timer, n_timer;
    logic [2:0] r_bit,   n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_pres,  n_pres;
    logic [7:0] r_rbyte, n_rbyte;

    logic       run;
    logic       fired;
    logic       rejected;
    logic [6:0] tpm;
    logic [6:0] presc_inc;
    logic [8:0] dur;
    logic [7:0] wr_stop;
    logic       wr_found;
    logic [2:0] wr_k;
    logic [3:0] tail_n;
    logic [7:0] rd_fill;
    logic       c2z, c3z, c4z, c5z, c6z, c7z;

    assign c2z = (i_cfg.presence_sample_time == '0);
    assign c3z = (i_cfg.reset_recovery_time  == '0);
    assign c4z = (i_cfg.write_one_low_time   == '0);
    assign c5z = (i_cfg.write_zero_low_time  == '0);
    assign c6z = (i_cfg.slot_recovery_time   == '0);
    assign c7z = (i_cfg.read_low_time        == '0);

    function automatic logic [8:0] phase_duration(input logic [3:0] ph, input logic bit0,
                                                  input obm_pkg::t_cfg c);
        logic [8:0] d;
        unique case (ph)
            obm_pkg::PH_RST_LOW: d = c.reset_low_time;
            obm_pkg::PH_RST_WT:  d = c.presence_sample_time;
            obm_pkg::PH_RST_REC: d = c.reset_recovery_time;
            obm_pkg::PH_WR_LOW:  d = bit0 ? c.write_one_low_time : c.write_zero_low_time;
            obm_pkg::PH_WR_REC:  d = c.slot_recovery_time;
            obm_pkg::PH_RD_LOW:  d = c.read_low_time;
            obm_pkg::PH_RD_REC:  d = c.slot_recovery_time;
            default:             d = '0;
        endcase
        return d;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_presc  = r_presc;
        n_timer  = r_timer;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_rbyte  = r_rbyte;
        run      = 1'b0;
        fired    = 1'b0;
        rejected = 1'b0;
        wr_stop  = '0;
        wr_found = 1'b0;
        wr_k     = '0;
        tail_n   = '0;
        rd_fill  = '0;
        tpm       = (i_cfg.ticks_per_microsecond == '0) ? 7'd1 : i_cfg.ticks_per_microsecond;
        presc_inc = r_presc + 7'd1;

        // advance timers, start a command, or reject a command while busy
        if (i_item.operation == obm_pkg::OP_TICK) begin
            if (r_phase != obm_pkg::PH_IDLE) begin
                run = 1'b1;
                if (presc_inc >= tpm) begin
                    n_presc = '0;
                    n_timer = r_timer + 9'd1;
                end else begin
                    n_presc = presc_inc;
                end
            end
        end else if (r_phase != obm_pkg::PH_IDLE) begin
            rejected = 1'b1;
        end else begin
            run     = 1'b1;
            n_bit   = '0;
            n_presc = '0;
            n_timer = '0;
            case (i_item.operation)
                obm_pkg::OP_RESET: n_phase = obm_pkg::PH_RST_LOW;
                obm_pkg::OP_WRITE: begin
                    n_phase = obm_pkg::PH_WR_LOW;
                    n_shift = i_item.write_byte;
                end
                default: begin
                    n_phase = obm_pkg::PH_RD_LOW;
                    n_shift = '0;
                end
            endcase
        end

        dur = phase_duration(n_phase, n_shift[0], i_cfg);

        // end the current phase once its time is reached
        if (run && n_phase != obm_pkg::PH_IDLE && n_timer >= dur) begin
            fired   = 1'b1;
            n_presc = '0;
            n_timer = '0;
            unique case (n_phase)
                obm_pkg::PH_RST_LOW: n_phase = obm_pkg::PH_RST_WT;
                obm_pkg::PH_RST_WT: begin
                    n_pres  = !i_item.line_level;
                    n_phase = obm_pkg::PH_RST_REC;
                end
                obm_pkg::PH_RST_REC: n_phase = obm_pkg::PH_IDLE;
                obm_pkg::PH_WR_LOW, obm_pkg::PH_WR_REC: begin
                    if (n_phase == obm_pkg::PH_WR_LOW && n_shift[0]) begin
                        n_phase = obm_pkg::PH_WR_REC;
                    end else begin
                        n_shift = n_shift >> 1;
                        if (n_bit == 3'd7) begin
                            n_phase = obm_pkg::PH_IDLE;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = obm_pkg::PH_WR_LOW;
                        end
                    end
                end
                obm_pkg::PH_RD_LOW: begin
                    n_shift = {i_item.line_level, n_shift[7:1]};
                    n_phase = obm_pkg::PH_RD_REC;
                end
                obm_pkg::PH_RD_REC: begin
                    if (n_bit == 3'd7) begin
                        n_rbyte = n_shift;
                        n_phase = obm_pkg::PH_IDLE;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = obm_pkg::PH_RD_LOW;
                    end
                end
                default: n_phase = obm_pkg::PH_IDLE;
            endcase
        end

        // pass straight through any following phases of zero length
        if (fired) begin
            if (n_phase == obm_pkg::PH_RST_WT && c2z) begin
                n_pres  = !i_item.line_level;
                n_phase = obm_pkg::PH_RST_REC;
            end
            if (n_phase == obm_pkg::PH_RST_REC && c3z) begin
                n_phase = obm_pkg::PH_IDLE;
            end

            if (n_phase == obm_pkg::PH_WR_REC && c6z) begin
                n_shift = n_shift >> 1;
                if (n_bit == 3'd7) begin
                    n_phase = obm_pkg::PH_IDLE;
                end else begin
                    n_bit   = n_bit + 3'd1;
                    n_phase = obm_pkg::PH_WR_LOW;
                end
            end
            if (n_phase == obm_pkg::PH_WR_LOW) begin
                // a bit stops the chain unless all of its slot times are zero
                for (int j = 0; j < 8; j++) begin
                    wr_stop[j] = (({1'b0, n_bit} + 4'(j)) <= 4'd7) &&
                                 (n_shift[j] ? !(c4z && c6z) : !c5z);
                end
                for (int j = 7; j >= 0; j--) begin
                    if (wr_stop[j]) begin
                        wr_found = 1'b1;
                        wr_k     = 3'(j);
                    end
                end
                if (wr_found) begin
                    n_shift = n_shift >> wr_k;
                    n_bit   = n_bit + wr_k;
                    n_phase = (n_shift[0] && c4z) ? obm_pkg::PH_WR_REC : obm_pkg::PH_WR_LOW;
                end else begin
                    tail_n  = 4'd8 - {1'b0, n_bit};
                    n_shift = n_shift >> tail_n;
                    n_bit   = 3'd7;
                    n_phase = obm_pkg::PH_IDLE;
                end
            end

            if (n_phase == obm_pkg::PH_RD_REC && c6z) begin
                if (n_bit == 3'd7) begin
                    n_rbyte = n_shift;
                    n_phase = obm_pkg::PH_IDLE;
                end else begin
                    n_bit   = n_bit + 3'd1;
                    n_phase = obm_pkg::PH_RD_LOW;
                end
            end
            if (n_phase == obm_pkg::PH_RD_LOW && c7z) begin
                if (c6z) begin
                    // every remaining bit samples the same level
                    tail_n  = 4'd8 - {1'b0, n_bit};
                    rd_fill = i_item.line_level ? ~(8'hFF >> tail_n) : 8'h00;
                    n_shift = (n_shift >> tail_n) | rd_fill;
                    n_rbyte = n_shift;
                    n_bit   = 3'd7;
                    n_phase = obm_pkg::PH_IDLE;
                end else begin
                    n_shift = {i_item.line_level, n_shift[7:1]};
                    n_phase = obm_pkg::PH_RD_REC;
                end
            end
        end

        o_res.line_drive_low   = (n_phase == obm_pkg::PH_RST_LOW) ||
                                 (n_phase == obm_pkg::PH_WR_LOW)  ||
                                 (n_phase == obm_pkg::PH_RD_LOW);
        o_res.busy_res         = (n_phase != obm_pkg::PH_IDLE);
        o_res.done_res         = run && (n_phase == obm_pkg::PH_IDLE);
        o_res.presence         = n_pres;
        o_res.read_byte        = n_rbyte;
        o_res.command_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= obm_pkg::PH_IDLE;
            r_presc <= '0;
            r_timer <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_rbyte <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_presc <= n_presc;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_rbyte <= n_rbyte;
        end
    end

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.command_rejected |=>
            r_phase == $past(r_phase) && r_timer == $past(r_timer))
        else $error("rejected command changed the bus state");

    a_idle_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == obm_pkg::PH_IDLE |-> !o_res.command_rejected)
        else $error("command rejected while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_phase == obm_pkg::PH_IDLE)
        else $error("done reported but phase not idle");

    a_hold_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_shift) && $stable(r_timer))
        else $error("state moved without a word");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.operation == obm_pkg::OP_TICK && r_phase == obm_pkg::PH_IDLE
            |=> r_phase == obm_pkg::PH_IDLE && $stable(r_rbyte))
        else $error("tick while idle changed state");

endmodule

[design/onewire_bus_master_top.sv]
// ----------------------------------------------------------------------------
// onewire_bus_master_top - 1-Wire bus master
// Path: an input word is taken into the input register, and its result word
// goes into the result register behind the bus update.
// Throughput: one word per cycle while the result register is free or being drained.
// Reset (synchronous, active low): phase idle, counters and bytes cleared,
// registers back to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module onewire_bus_master_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    obm_in_if.sink                         i_in,
    obm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [obm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [obm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           r_in_valid;
    obm_pkg::t_item r_in_item;
    logic           r_out_valid;
    obm_pkg::t_res  r_out_res;
    logic           step;
    obm_pkg::t_cfg  cfg;
    obm_pkg::t_res  core_res;

    // advance a word when the result register is free or being drained
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    obm_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    obm_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_item (r_in_item),
        .i_cfg  (cfg),
        .o_res  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.operation  <= i_in.operation;
            r_in_item.write_byte <= i_in.write_byte;
            r_in_item.line_level <= i_in.line_level;
        end
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.line_drive_low   = r_out_res.line_drive_low;
    assign o_out.busy_res         = r_out_res.busy_res;
    assign o_out.done_res         = r_out_res.done_res;
    assign o_out.presence         = r_out_res.presence;
    assign o_out.read_byte        = r_out_res.read_byte;
    assign o_out.command_rejected = r_out_res.command_rejected;

endmodule

[tb/onewire_bus_master_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// onewire_bus_master_top_tb - self-checking bench for the 1-Wire bus master
// Feeds tick and command words through the input channel and compares every
// status word against an in-bench model of the bus phases or a pinned word.
// A short directed table covers the reset timing, zero-length phases, the slowest
// settings and rejected commands. Random command sequences with random line levels
// follow, under several register settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module onewire_bus_master_top_tb;

    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TOTAL_ITEMS    = 1000;
    localparam int RAND_SETTINGS  = 6;
    localparam int PLAN_ROWS      = 19;

    typedef logic [obm_pkg::CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [obm_pkg::CFG_DATA_W-1:0] t_cfg_data;

    typedef struct {
        int             cfg_sel;
        obm_pkg::t_item word;
        int             reps;
        bit             pinned;
        obm_pkg::t_res  status;
    } t_plan_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    obm_in_if  in_bus ();
    obm_out_if out_bus ();

    onewire_bus_master_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // bus model state
    obm_pkg::t_cfg bus_cfg;
    logic [3:0]    bus_phase;
    logic [6:0]    bus_presc;
    logic [8:0]    bus_usec;
    logic [2:0]    bus_bit;
    logic [7:0]    bus_shift;
    logic          bus_presence;
    logic [7:0]    bus_rx_byte;

    obm_pkg::t_res bus_status_q [$];
    int            mismatch_cnt = 0;
    int            sent_items   = 0;
    bit            idling_on    = 1'b1;
    int            rx_hold      = 0;

    obm_pkg::t_cfg dir_settings [4];

    t_plan_row dir_plan [PLAN_ROWS] = '{
        '{0, '{obm_pkg::OP_TICK,  8'h00, 1'b1},   1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{0, '{obm_pkg::OP_RESET, 8'h00, 1'b1},   1, 1'b0, '0},
        '{0, '{obm_pkg::OP_TICK,  8'h00, 1'b0},  24, 1'b0, '0},
        '{0, '{obm_pkg::OP_WRITE, 8'hA5, 1'b1},   1, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{0, '{obm_pkg::OP_READ,  8'h00, 1'b0},   1, 1'b0, '0},
        '{0, '{obm_pkg::OP_TICK,  8'h00, 1'b1},  20, 1'b0, '0},
        // all phases zero length: every command completes on its own word
        '{1, '{obm_pkg::OP_TICK,  8'h00, 1'b1},   1, 1'b0, '0},
        '{1, '{obm_pkg::OP_RESET, 8'h00, 1'b0},   1, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}},
        '{1, '{obm_pkg::OP_RESET, 8'h00, 1'b1},   1, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1, '{obm_pkg::OP_READ,  8'h00, 1'b1},   1, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0}},
        '{1, '{obm_pkg::OP_WRITE, 8'h00, 1'b1},   1, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0}},
        '{1, '{obm_pkg::OP_READ,  8'hFF, 1'b0},   1, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1, '{obm_pkg::OP_TICK,  8'hFF, 1'b0},   1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        // longest phases: run the timer up to its top value
        '{2, '{obm_pkg::OP_WRITE, 8'h5A, 1'b0},   1, 1'b0, '0},
        '{2, '{obm_pkg::OP_RESET, 8'h00, 1'b0},   1, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{2, '{obm_pkg::OP_TICK,  8'h00, 1'b1}, 512, 1'b0, '0},
        // widest prescale
        '{3, '{obm_pkg::OP_TICK,  8'h00, 1'b1},   1, 1'b0, '0},
        '{3, '{obm_pkg::OP_READ,  8'h00, 1'b1},   1, 1'b0, '0},
        '{3, '{obm_pkg::OP_TICK,  8'h00, 1'b0}, 130, 1'b0, '0}
    };

    function automatic logic [8:0] phase_len();
        case (bus_phase)
            obm_pkg::PH_RST_LOW: return bus_cfg.reset_low_time;
            obm_pkg::PH_RST_WT:  return bus_cfg.presence_sample_time;
            obm_pkg::PH_RST_REC: return bus_cfg.reset_recovery_time;
            obm_pkg::PH_WR_LOW:  return bus_shift[0] ? bus_cfg.write_one_low_time
                                                     : bus_cfg.write_zero_low_time;
            obm_pkg::PH_WR_REC:  return bus_cfg.slot_recovery_time;
            obm_pkg::PH_RD_LOW:  return bus_cfg.read_low_time;
            obm_pkg::PH_RD_REC:  return bus_cfg.slot_recovery_time;
            default:             return 9'd0;
        endcase
    endfunction

    function automatic void enter_phase(logic [3:0] next);
        bus_phase = next;
        bus_presc = '0;
        bus_usec  = '0;
    endfunction

    function automatic void next_write_bit();
        bus_shift = bus_shift >> 1;
        if (bus_bit == 3'd7) begin
            enter_phase(obm_pkg::PH_IDLE);
        end else begin
            bus_bit = bus_bit + 3'd1;
            enter_phase(obm_pkg::PH_WR_LOW);
        end
    endfunction

    function automatic void end_phase(logic line);
        case (bus_phase)
            obm_pkg::PH_RST_LOW: enter_phase(obm_pkg::PH_RST_WT);
            obm_pkg::PH_RST_WT: begin
                bus_presence = ~line;
                enter_phase(obm_pkg::PH_RST_REC);
            end
            obm_pkg::PH_RST_REC: enter_phase(obm_pkg::PH_IDLE);
            obm_pkg::PH_WR_LOW: begin
                // a zero bit goes straight to the next slot
                if (bus_shift[0]) enter_phase(obm_pkg::PH_WR_REC);
                else next_write_bit();
            end
            obm_pkg::PH_WR_REC: next_write_bit();
            obm_pkg::PH_RD_LOW: begin
                bus_shift = {line, bus_shift[7:1]};
                enter_phase(obm_pkg::PH_RD_REC);
            end
            obm_pkg::PH_RD_REC: begin
                if (bus_bit == 3'd7) begin
                    bus_rx_byte = bus_shift;
                    enter_phase(obm_pkg::PH_IDLE);
                end else begin
                    bus_bit = bus_bit + 3'd1;
                    enter_phase(obm_pkg::PH_RD_LOW);
                end
            end
            default: enter_phase(obm_pkg::PH_IDLE);
        endcase
    endfunction

    function automatic void settle_phases(logic line);
        while (bus_phase != obm_pkg::PH_IDLE && bus_usec >= phase_len())
            end_phase(line);
    endfunction

    function automatic obm_pkg::t_res advance_bus(obm_pkg::t_item w);
        logic          was_busy;
        logic [6:0]    tpm;
        obm_pkg::t_res r;
        was_busy = (bus_phase != obm_pkg::PH_IDLE);
        r = '0;
        if (w.operation == obm_pkg::OP_TICK) begin
            if (was_busy) begin
                tpm = (bus_cfg.ticks_per_microsecond == 7'd0) ? 7'd1
                                                              : bus_cfg.ticks_per_microsecond;
                bus_presc = bus_presc + 7'd1;
                if (bus_presc >= tpm) begin
                    bus_presc = '0;
                    bus_usec  = bus_usec + 9'd1;
                end
                settle_phases(w.line_level);
                r.done_res = (bus_phase == obm_pkg::PH_IDLE);
            end
        end else if (was_busy) begin
            r.command_rejected = 1'b1;
        end else begin
            bus_bit = '0;
            case (w.operation)
                obm_pkg::OP_RESET: enter_phase(obm_pkg::PH_RST_LOW);
                obm_pkg::OP_WRITE: begin
                    bus_shift = w.write_byte;
                    enter_phase(obm_pkg::PH_WR_LOW);
                end
                default: begin
                    bus_shift = '0;
                    enter_phase(obm_pkg::PH_RD_LOW);
                end
            endcase
            settle_phases(w.line_level);
            r.done_res = (bus_phase == obm_pkg::PH_IDLE);
        end
        r.line_drive_low = (bus_phase == obm_pkg::PH_RST_LOW) ||
                           (bus_phase == obm_pkg::PH_WR_LOW)  ||
                           (bus_phase == obm_pkg::PH_RD_LOW);
        r.busy_res  = (bus_phase != obm_pkg::PH_IDLE);
        r.presence  = bus_presence;
        r.read_byte = bus_rx_byte;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned due, int unsigned got);
        if (due != got) begin
            $error("%s: expected %0d, actual %0d", name, due, got);
            mismatch_cnt++;
        end
    endfunction

    // Call at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(obm_pkg::t_item w, bit pinned, obm_pkg::t_res status);
        obm_pkg::t_res due;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= w.operation;
        in_bus.write_byte <= w.write_byte;
        in_bus.line_level <= w.line_level;
        do @(posedge i_clk); while (!in_bus.ready);
        sent_items++;
        due = advance_bus(w);
        bus_status_q.push_back(pinned ? status : due);
    endtask

    // Hold off input until every status word is back and the block is quiet.
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (bus_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(obm_pkg::t_cfg c);
        put_reg(obm_pkg::CFG_TPM,      t_cfg_data'(c.ticks_per_microsecond));
        put_reg(obm_pkg::CFG_RST_LOW,  c.reset_low_time);
        put_reg(obm_pkg::CFG_PRES_SMP, c.presence_sample_time);
        put_reg(obm_pkg::CFG_RST_REC,  c.reset_recovery_time);
        put_reg(obm_pkg::CFG_WR1_LOW,  c.write_one_low_time);
        put_reg(obm_pkg::CFG_WR0_LOW,  c.write_zero_low_time);
        put_reg(obm_pkg::CFG_SLOT_REC, c.slot_recovery_time);
        put_reg(obm_pkg::CFG_RD_LOW,   c.read_low_time);
        i_cfg_we <= 1'b0;
        bus_cfg = c;
    endtask

    // result side: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            out_bus.ready <= (rx_hold == 1);
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rx_hold <= $urandom_range(1, 7);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : status_check
        obm_pkg::t_res due;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (bus_status_q.size() == 0) begin
                $error("status word with none pending");
                mismatch_cnt++;
            end else begin
                due = bus_status_q.pop_front();
                check_field("line_drive_low", due.line_drive_low, out_bus.line_drive_low);
                check_field("busy_res", due.busy_res, out_bus.busy_res);
                check_field("done_res", due.done_res, out_bus.done_res);
                check_field("presence", due.presence, out_bus.presence);
                check_field("read_byte", due.read_byte, out_bus.read_byte);
                check_field("command_rejected", due.command_rejected,
                            out_bus.command_rejected);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        obm_pkg::t_item w;
        obm_pkg::t_cfg  c;
        int             cur_sel;
        int             base;
        int             goal;
        int             pick;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= obm_pkg::CFG_TPM;
        i_cfg_data        <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= obm_pkg::OP_TICK;
        in_bus.write_byte <= '0;
        in_bus.line_level <= 1'b1;

        dir_settings[0] = '{obm_pkg::TPM_RESET, obm_pkg::RST_LOW_RESET,
                            obm_pkg::PRES_SMP_RESET, obm_pkg::RST_REC_RESET,
                            obm_pkg::WR1_LOW_RESET, obm_pkg::WR0_LOW_RESET,
                            obm_pkg::SLOT_REC_RESET, obm_pkg::RD_LOW_RESET};
        dir_settings[1] = '0;
        dir_settings[2] = '{7'd1, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511};
        dir_settings[3] = '{7'd127, 9'd1, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 9'd1};

        bus_cfg      = dir_settings[0];
        bus_phase    = obm_pkg::PH_IDLE;
        bus_presc    = '0;
        bus_usec     = '0;
        bus_bit      = '0;
        bus_shift    = '0;
        bus_presence = 1'b0;
        bus_rx_byte  = '0;
        cur_sel      = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_plan[i]) begin
            if (dir_plan[i].cfg_sel != cur_sel) begin
                wait_idle();
                cur_sel = dir_plan[i].cfg_sel;
                apply_settings(dir_settings[cur_sel]);
            end
            repeat (dir_plan[i].reps)
                send_word(dir_plan[i].word, dir_plan[i].pinned, dir_plan[i].status);
        end

        base = sent_items;
        for (int k = 0; k < RAND_SETTINGS; k++) begin
            c.ticks_per_microsecond = 7'($urandom_range(0, 2));
            c.reset_low_time        = 9'($urandom_range(0, 3));
            c.presence_sample_time  = 9'($urandom_range(0, 3));
            c.reset_recovery_time   = 9'($urandom_range(0, 3));
            c.write_one_low_time    = 9'($urandom_range(0, 3));
            c.write_zero_low_time   = 9'($urandom_range(0, 3));
            c.slot_recovery_time    = 9'($urandom_range(0, 3));
            c.read_low_time         = 9'($urandom_range(0, 3));
            wait_idle();
            apply_settings(c);
            // no idling in the last stretch
            idling_on = (k != RAND_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
            goal = base + (k + 1) * (TOTAL_ITEMS - base) / RAND_SETTINGS;
            while (sent_items < goal) begin
                // mostly a command followed by ticks until it completes
                pick = $urandom_range(0, 9);
                w.operation  = (pick == 0)
                               ? 2'($urandom_range(obm_pkg::OP_TICK, obm_pkg::OP_READ))
                               : 2'($urandom_range(obm_pkg::OP_RESET, obm_pkg::OP_READ));
                w.write_byte = 8'($urandom_range(0, 255));
                w.line_level = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, '0);
                while (pick != 0 && bus_phase != obm_pkg::PH_IDLE) begin
                    w.operation  = ($urandom_range(0, 15) == 0)
                                   ? 2'($urandom_range(obm_pkg::OP_RESET, obm_pkg::OP_READ))
                                   : obm_pkg::OP_TICK;
                    w.write_byte = 8'($urandom_range(0, 255));
                    w.line_level = 1'($urandom_range(0, 1));
                    send_word(w, 1'b0, '0);
                end
                if ($urandom_range(0, 9) == 0) begin
                    w.operation = obm_pkg::OP_TICK;
                    send_word(w, 1'b0, '0);
                end
            end
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/obm_pkg.sv
design/obm_if.sv
design/obm_cfg.sv
design/obm_core.sv
design/onewire_bus_master_top.sv
tb/onewire_bus_master_top_tb.sv
